// ----- rtl/core/port_session_stats_table_unit_assert.svh -----
// assertion macros for the port session statistics table
// depends on a clk_i and an active-low rst_ni in the scope of use
`ifndef PORT_SESSION_STATS_TABLE_UNIT_ASSERT_SVH
`define PORT_SESSION_STATS_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define PSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("port session stats check failed");

// next-cycle implication, off during reset
`define PSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("port session stats check failed");

`endif

// ----- rtl/core/pss_pkg.sv -----
// shared types and constants of the port session statistics table
// no dependencies
package pss_pkg;

  localparam int unsigned PORTS = 1024;
  localparam int unsigned IDX_W = $clog2(PORTS);
  localparam int unsigned PTR_W = $clog2(PORTS + 1);
  localparam int unsigned CFG_W = 11;
  localparam int unsigned CNT_W = 11;
  localparam logic [CFG_W-1:0] MAX_PORTS_RST = CFG_W'(1024);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_ALIVE = 2'd2,
    OP_OTHER = 2'd3
  } pss_op_e;

  typedef enum logic [1:0] {
    STS_UPDATED = 2'd0,
    STS_IGNORED = 2'd1,
    STS_FULL    = 2'd2
  } pss_status_e;

  typedef struct packed {
    logic        active;
    logic        start_valid;
    logic [31:0] sessions;
    logic [31:0] ref_time;
    logic [31:0] idle_sum;
    logic [31:0] inuse_sum;
    logic [31:0] longest_idle;
    logic [31:0] longest_sess;
  } pss_stats_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic take_hit;
    logic take_append;
    logic set_ignored;
    logic set_full;
    logic commit;
  } pss_cmd_t;

  typedef struct packed {
    logic addr_zero;
    logic hit;
    logic scan_done;
    logic room;
    logic out_free;
  } pss_sts_t;

endpackage

// ----- rtl/core/pss_ctrl.sv -----
// controller state machine of the port session statistics table
// depends on pss_pkg
module pss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pss_pkg::pss_sts_t sts_i,
  output pss_pkg::pss_cmd_t cmd_o
);
  import pss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FETCH  = 4'b0100,
    ST_UPDATE = 4'b1000
  } pss_state_e;

  pss_state_e state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (sts_i.addr_zero) begin
            cmd_o.set_ignored = 1'b1;
            state_d = ST_UPDATE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.hit) begin
          cmd_o.take_hit = 1'b1;
          state_d = ST_FETCH;
        end else if (sts_i.scan_done) begin
          if (sts_i.room) begin
            cmd_o.take_append = 1'b1;
            state_d = ST_FETCH;
          end else begin
            cmd_o.set_full = 1'b1;
            state_d = ST_UPDATE;
          end
        end
      end
      ST_FETCH: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/pss_datapath.sv -----
// datapath: port table memories, scan pointer, entry update and result register
// depends on pss_pkg
module pss_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pss_pkg::pss_cmd_t        cmd_i,
  output pss_pkg::pss_sts_t        sts_o,
  input  logic                     cfg_valid_i,
  input  logic [pss_pkg::CFG_W-1:0] cfg_data_i,
  input  logic [1:0]               op_i,
  input  logic [31:0]              nas_net_address_i,
  input  logic [31:0]              nas_net_mask_i,
  input  logic [15:0]              port_number_i,
  input  logic [31:0]              event_time_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               status_o,
  output logic [10:0]              entry_index_o,
  output logic                     negative_interval_o,
  output logic                     port_active_o,
  output logic [31:0]              session_count_o,
  output logic [31:0]              idle_total_o,
  output logic [31:0]              inuse_total_o,
  output logic [31:0]              longest_idle_o,
  output logic [31:0]              longest_session_o,
  output logic [pss_pkg::CNT_W-1:0] active_ports_o,
  output logic [pss_pkg::CNT_W-1:0] idle_ports_o
);
  import pss_pkg::*;

  // table memories; entries past the fill count are never compared, an appended entry starts from zero
  logic [47:0]  key_mem   [PORTS];
  pss_stats_t   stats_mem [PORTS];
  logic [47:0]  key_rd_q;
  pss_stats_t   stats_rd_q;

  logic [CFG_W-1:0] max_ports_q;
  logic [PTR_W-1:0] used_q, active_q, scan_q, rd_ptr_q;
  logic [IDX_W-1:0] pend_idx_q, idx_q;
  logic             pend_q, found_q, fresh_q;
  pss_status_e      status_q;

  pss_op_e     op_q;
  logic [31:0] addr_q, mask_q, time_q;
  logic [15:0] port_q;

  logic [PTR_W-1:0] lim, used_upd, active_upd;
  pss_stats_t       s_cur, s_new;
  logic             neg;
  logic [31:0]      dt;
  logic [32:0]      sum_idle, sum_inuse;
  logic             out_valid_q;

  // effective entry limit
  assign lim = (32'(max_ports_q) > PORTS) ? PTR_W'(PORTS) : PTR_W'(max_ports_q);

  assign sts_o.addr_zero = (nas_net_address_i == 32'd0);
  assign sts_o.hit       = pend_q && ((key_rd_q[47:16] & mask_q) == (addr_q & mask_q))
                           && (key_rd_q[15:0] == port_q);
  assign sts_o.scan_done = !pend_q && (rd_ptr_q >= scan_q);
  assign sts_o.room      = (used_q < lim);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ports_q <= MAX_PORTS_RST;
    end else if (cfg_valid_i) begin
      max_ports_q <= cfg_data_i;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= pss_op_e'(op_i);
      addr_q <= nas_net_address_i;
      mask_q <= nas_net_mask_i;
      port_q <= port_number_i;
      time_q <= event_time_i;
      scan_q <= (used_q < lim) ? used_q : lim;
    end
  end

  // registered memory reads
  always_ff @(posedge clk_i) begin
    key_rd_q   <= key_mem[rd_ptr_q[IDX_W-1:0]];
    stats_rd_q <= stats_mem[idx_q];
  end

  // memory writes on commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && found_q) begin
      stats_mem[idx_q] <= s_new;
      if (fresh_q) begin
        key_mem[idx_q] <= {addr_q, port_q};
      end
    end
  end

  // scan pointer, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
    end else if (cmd_i.scan_start) begin
      rd_ptr_q <= '0;
      pend_q   <= 1'b0;
    end else if (cmd_i.scan_run && rd_ptr_q < scan_q) begin
      rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      pend_q   <= 1'b1;
    end else begin
      pend_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= rd_ptr_q[IDX_W-1:0];
  end

  // entry selection and status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q  <= 1'b0;
      fresh_q  <= 1'b0;
      status_q <= STS_UPDATED;
      idx_q    <= '0;
    end else if (cmd_i.set_ignored) begin
      found_q  <= 1'b0;
      status_q <= STS_IGNORED;
    end else if (cmd_i.set_full) begin
      found_q  <= 1'b0;
      status_q <= STS_FULL;
    end else if (cmd_i.take_hit) begin
      found_q  <= 1'b1;
      fresh_q  <= 1'b0;
      status_q <= STS_UPDATED;
      idx_q    <= pend_idx_q;
    end else if (cmd_i.take_append) begin
      found_q  <= 1'b1;
      fresh_q  <= 1'b1;
      status_q <= STS_UPDATED;
      idx_q    <= used_q[IDX_W-1:0];
    end
  end

  // entry update
  always_comb begin
    s_cur     = fresh_q ? '0 : stats_rd_q;
    s_new     = s_cur;
    neg       = 1'b0;
    dt        = time_q - s_cur.ref_time;
    sum_idle  = {1'b0, s_cur.idle_sum} + {1'b0, dt};
    sum_inuse = {1'b0, s_cur.inuse_sum} + {1'b0, dt};
    case (op_q)
      OP_START, OP_STOP: begin
        if (s_cur.start_valid) begin
          if (time_q < s_cur.ref_time) begin
            neg = 1'b1;
          end else if (op_q == OP_START) begin
            s_new.idle_sum = sum_idle[32] ? 32'hFFFF_FFFF : sum_idle[31:0];
            if (dt > s_cur.longest_idle) begin
              s_new.longest_idle = dt;
            end
          end else begin
            s_new.inuse_sum = sum_inuse[32] ? 32'hFFFF_FFFF : sum_inuse[31:0];
            if (dt > s_cur.longest_sess) begin
              s_new.longest_sess = dt;
            end
          end
        end
        if (op_q == OP_START) begin
          s_new.active = 1'b1;
          if (s_cur.sessions != 32'hFFFF_FFFF) begin
            s_new.sessions = s_cur.sessions + 32'd1;
          end
        end else begin
          s_new.active = 1'b0;
        end
        s_new.ref_time    = time_q;
        s_new.start_valid = 1'b1;
      end
      OP_ALIVE: begin
        s_new.active = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // live port counts after the update
  always_comb begin
    used_upd   = used_q;
    active_upd = active_q;
    if (found_q) begin
      if (fresh_q) begin
        used_upd = used_q + PTR_W'(1);
      end
      if (s_new.active && !s_cur.active) begin
        active_upd = active_q + PTR_W'(1);
      end else if (!s_new.active && s_cur.active) begin
        active_upd = active_q - PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      active_q <= '0;
    end else if (cmd_i.commit) begin
      used_q   <= used_upd;
      active_q <= active_upd;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o            <= status_q;
      entry_index_o       <= found_q ? 11'({1'b0, idx_q} + (IDX_W + 1)'(1)) : 11'd0;
      negative_interval_o <= found_q && neg;
      port_active_o       <= found_q && s_new.active;
      session_count_o     <= found_q ? s_new.sessions : 32'd0;
      idle_total_o        <= found_q ? s_new.idle_sum : 32'd0;
      inuse_total_o       <= found_q ? s_new.inuse_sum : 32'd0;
      longest_idle_o      <= found_q ? s_new.longest_idle : 32'd0;
      longest_session_o   <= found_q ? s_new.longest_sess : 32'd0;
      active_ports_o      <= CNT_W'(active_upd);
      idle_ports_o        <= CNT_W'(used_upd - active_upd);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/port_session_stats_table_unit.sv -----
// port session statistics table: one result per accounting event
// flow: the scan reads one key per cycle; a match or an append goes on to the entry
//   fetch and update, a full table or a zero address goes straight to the update
// a new event is taken only once the result of the last one is committed
// reset: table empty (fill count cleared, no clearing pass), limit 1024, no result pending
// depends on pss_pkg, pss_ctrl, pss_datapath
module port_session_stats_table_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [pss_pkg::CFG_W-1:0] cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                op_i,
  input  logic [31:0]               nas_net_address_i,
  input  logic [31:0]               nas_net_mask_i,
  input  logic [15:0]               port_number_i,
  input  logic [31:0]               event_time_i,
  input  logic [31:0]               framed_ip_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [10:0]               entry_index_o,
  output logic                      negative_interval_o,
  output logic                      port_active_o,
  output logic [31:0]               session_count_o,
  output logic [31:0]               idle_total_o,
  output logic [31:0]               inuse_total_o,
  output logic [31:0]               longest_idle_o,
  output logic [31:0]               longest_session_o,
  output logic [pss_pkg::CNT_W-1:0] active_ports_o,
  output logic [pss_pkg::CNT_W-1:0] idle_ports_o
);
  import pss_pkg::*;

  pss_cmd_t cmd;
  pss_sts_t sts;

  // framed address is kept by no result field
  assign cfg_ready_o = 1'b1;

  pss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pss_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_data_i          (cfg_data_i),
    .op_i                (op_i),
    .nas_net_address_i   (nas_net_address_i),
    .nas_net_mask_i      (nas_net_mask_i),
    .port_number_i       (port_number_i),
    .event_time_i        (event_time_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .entry_index_o       (entry_index_o),
    .negative_interval_o (negative_interval_o),
    .port_active_o       (port_active_o),
    .session_count_o     (session_count_o),
    .idle_total_o        (idle_total_o),
    .inuse_total_o       (inuse_total_o),
    .longest_idle_o      (longest_idle_o),
    .longest_session_o   (longest_session_o),
    .active_ports_o      (active_ports_o),
    .idle_ports_o        (idle_ports_o)
  );

endmodule

// ----- rtl/core/pss_checker.sv -----
// port-level checks of the port session statistics table, bound to the top level
// depends on pss_pkg and port_session_stats_table_unit_assert.svh
`include "port_session_stats_table_unit_assert.svh"
module pss_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic [1:0]                status_o,
  input logic [10:0]               entry_index_o,
  input logic                      port_active_o,
  input logic [31:0]               session_count_o
);
  import pss_pkg::*;

  // updated requests name an entry, others name none
  `PSS_ASSERT_NOW(a_upd_index, out_valid_o && status_o == STS_UPDATED, entry_index_o != 11'd0)
  `PSS_ASSERT_NOW(a_skip_index, out_valid_o && status_o != STS_UPDATED, entry_index_o == 11'd0)
  // full table leaves the entry fields clear
  `PSS_ASSERT_NOW(a_full_zero, out_valid_o && status_o == STS_FULL,
    !port_active_o && session_count_o == 32'd0)
  // no status code beyond table full
  `PSS_ASSERT_NOW(a_status_code, out_valid_o, status_o <= STS_FULL)
  // an accepted request stalls the input until its result is built
  `PSS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind port_session_stats_table_unit pss_checker u_pss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .status_o       (status_o),
  .entry_index_o  (entry_index_o),
  .port_active_o  (port_active_o),
  .session_count_o(session_count_o)
);

// ----- bench/testbench.sv -----
// self-checking bench for the port session statistics table
// depends on pss_pkg and port_session_stats_table_unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pss_pkg::*;

  // one accounting request and one table result
  typedef struct {
    pss_op_e     op;
    logic [31:0] addr;
    logic [31:0] mask;
    logic [15:0] port;
    logic [31:0] tstamp;
    logic [31:0] framed;
  } acct_req_t;

  typedef struct {
    pss_status_e status;
    logic [10:0] idx;
    logic        neg;
    logic        act;
    logic [31:0] sessions;
    logic [31:0] idle_sum;
    logic [31:0] inuse_sum;
    logic [31:0] long_idle;
    logic [31:0] long_sess;
    logic [10:0] act_ports;
    logic [10:0] idle_ports;
  } port_stats_t;

  // directed row: request plus status and index where they are obvious
  typedef struct {
    acct_req_t   req;
    bit          typed;
    pss_status_e status;
    logic [10:0] idx;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [10:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = '0;
  logic [31:0] nas_net_address_i = '0;
  logic [31:0] nas_net_mask_i = '0;
  logic [15:0] port_number_i = '0;
  logic [31:0] event_time_i = '0;
  logic [31:0] framed_ip_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [10:0] entry_index_o;
  logic        negative_interval_o;
  logic        port_active_o;
  logic [31:0] session_count_o, idle_total_o, inuse_total_o;
  logic [31:0] longest_idle_o, longest_session_o;
  logic [10:0] active_ports_o, idle_ports_o;

  port_session_stats_table_unit DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of the port table, statistics all zero at start
  logic [10:0] limit_reg = 11'd1024;
  logic [31:0] tbl_addr [PORTS];
  logic [15:0] tbl_port [PORTS];
  bit          tbl_act [PORTS];
  bit          tbl_tvalid [PORTS];
  bit   [31:0] tbl_sess [PORTS];
  bit   [31:0] tbl_tstart [PORTS];
  bit   [31:0] tbl_idle [PORTS];
  bit   [31:0] tbl_inuse [PORTS];
  bit   [31:0] tbl_lidle [PORTS];
  bit   [31:0] tbl_lsess [PORTS];
  int unsigned used_cnt = 0;
  int unsigned act_cnt = 0;

  port_stats_t pending_stats [$];
  int unsigned errors = 0;
  int unsigned n_results = 0, n_full = 0, n_ignored = 0, n_neg = 0;
  bit          hold_go = 1'b0;
  int unsigned stall_pct = 0;

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void mark_active(int unsigned i, bit v);
    if (tbl_act[i] != v) begin
      if (v) act_cnt++;
      else act_cnt--;
      tbl_act[i] = v;
    end
  endfunction

  // table update for one request, returns the expected result
  function automatic port_stats_t table_update(acct_req_t r);
    port_stats_t res;
    int unsigned lim, scan, idx;
    bit          hit;
    logic [31:0] dt;
    res = '{STS_UPDATED, '0, 1'b0, 1'b0, '0, '0, '0, '0, '0, '0, '0};
    lim = (limit_reg > PORTS) ? PORTS : limit_reg;
    scan = (used_cnt < lim) ? used_cnt : lim;
    hit = 1'b0;
    idx = 0;
    if (r.addr == 32'd0) begin
      res.status = STS_IGNORED;
    end else begin
      for (int unsigned i = 0; i < scan && !hit; i++) begin
        if ((tbl_addr[i] & r.mask) == (r.addr & r.mask) && tbl_port[i] == r.port) begin
          hit = 1'b1;
          idx = i;
        end
      end
      if (!hit) begin
        if (used_cnt < lim) begin
          idx = used_cnt;
          used_cnt++;
          tbl_addr[idx] = r.addr;
          tbl_port[idx] = r.port;
          hit = 1'b1;
        end else begin
          res.status = STS_FULL;
        end
      end
    end
    if (hit) begin
      if (r.op == OP_START || r.op == OP_STOP) begin
        // interval since the stored start time, only once one exists
        if (tbl_tvalid[idx]) begin
          if (r.tstamp < tbl_tstart[idx]) begin
            res.neg = 1'b1;
          end else begin
            dt = r.tstamp - tbl_tstart[idx];
            if (r.op == OP_START) begin
              tbl_idle[idx] = sat_sum(tbl_idle[idx], dt);
              if (dt > tbl_lidle[idx]) tbl_lidle[idx] = dt;
            end else begin
              tbl_inuse[idx] = sat_sum(tbl_inuse[idx], dt);
              if (dt > tbl_lsess[idx]) tbl_lsess[idx] = dt;
            end
          end
        end
        if (r.op == OP_START) begin
          mark_active(idx, 1'b1);
          if (tbl_sess[idx] != 32'hFFFF_FFFF) tbl_sess[idx]++;
        end else begin
          mark_active(idx, 1'b0);
        end
        tbl_tstart[idx] = r.tstamp;
        tbl_tvalid[idx] = 1'b1;
      end else if (r.op == OP_ALIVE) begin
        mark_active(idx, 1'b1);
      end
      res.idx = 11'(idx + 1);
      res.act = tbl_act[idx];
      res.sessions = tbl_sess[idx];
      res.idle_sum = tbl_idle[idx];
      res.inuse_sum = tbl_inuse[idx];
      res.long_idle = tbl_lidle[idx];
      res.long_sess = tbl_lsess[idx];
    end
    res.act_ports = 11'(act_cnt);
    res.idle_ports = 11'(used_cnt - act_cnt);
    return res;
  endfunction

  // offer one request and hold it until the block takes it
  task automatic offer_request(acct_req_t r, bit typed = 1'b0,
                               pss_status_e t_status = STS_UPDATED,
                               logic [10:0] t_idx = '0);
    port_stats_t res;
    in_valid_i <= 1'b1;
    op_i <= r.op;
    nas_net_address_i <= r.addr;
    nas_net_mask_i <= r.mask;
    port_number_i <= r.port;
    event_time_i <= r.tstamp;
    framed_ip_i <= r.framed;
    do @(posedge clk_i); while (in_stall_o);
    res = table_update(r);
    if (typed) begin
      res.status = t_status;
      res.idx = t_idx;
    end
    pending_stats.push_back(res);
  endtask

  task automatic idle_gap(int unsigned cycles);
    if (cycles != 0) begin
      in_valid_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // write the port limit once every result is back
  task automatic write_limit(logic [10:0] v);
    in_valid_i <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_reg = v;
  endtask

  // random request, mostly on a small set of servers and ports
  logic [31:0] srv_pool [8];
  logic [15:0] port_pool [4];
  logic [31:0] clock_s = 32'd1000;

  function automatic acct_req_t random_request();
    acct_req_t   r;
    int unsigned k;
    k = $urandom_range(99);
    r.op = pss_op_e'((k < 40) ? OP_START : (k < 80) ? OP_STOP : $urandom_range(3));
    k = $urandom_range(99);
    if (k < 5) begin
      r.addr = 32'd0;
      r.port = 16'($urandom);
    end else if (k < 15) begin
      r.addr = $urandom;
      r.port = 16'($urandom);
    end else begin
      r.addr = srv_pool[$urandom_range(7)];
      r.port = port_pool[$urandom_range(3)];
    end
    k = $urandom_range(99);
    r.mask = (k < 70) ? 32'hFFFF_FFFF : (k < 80) ? 32'hFFFF_0000 :
             (k < 88) ? 32'h0 : $urandom;
    clock_s = clock_s + $urandom_range(5000);
    r.tstamp = ($urandom_range(99) < 5) ? $urandom : clock_s;
    r.framed = $urandom;
    return r;
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned burst;
    burst = $urandom_range(1, 12);
    for (int unsigned i = 0; i < n; i++) begin
      offer_request(random_request());
      if (--burst == 0) begin
        burst = $urandom_range(1, 12);
        idle_gap($urandom_range(0, 9));
      end
    end
  endtask

  // receiver: stalls at a randomly redrawn density, long hold on request
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk_i);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
      end else begin
        if (cyc % 64 == 0) stall_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 90);
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
      cyc++;
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t ns: %s expected %0h got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    port_stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_stats.size() == 0) begin
        errors++;
        $display("%0t ns: result with nothing expected, status %0d index %0d",
                 $time, status_o, entry_index_o);
      end else begin
        e = pending_stats.pop_front();
        n_results++;
        if (e.status == STS_FULL) n_full++;
        if (e.status == STS_IGNORED) n_ignored++;
        if (e.neg) n_neg++;
        check_field("status", e.status, status_o);
        check_field("entry_index", e.idx, entry_index_o);
        check_field("negative_interval", e.neg, negative_interval_o);
        check_field("port_active", e.act, port_active_o);
        check_field("session_count", e.sessions, session_count_o);
        check_field("idle_total", e.idle_sum, idle_total_o);
        check_field("inuse_total", e.inuse_sum, inuse_total_o);
        check_field("longest_idle", e.long_idle, longest_idle_o);
        check_field("longest_session", e.long_sess, longest_session_o);
        check_field("active_ports", e.act_ports, active_ports_o);
        check_field("idle_ports", e.idle_ports, idle_ports_o);
      end
    end
  end

  // directed rows on an empty table with the reset limit
  dir_row_t dir_rows [14] = '{
    '{'{OP_START, 32'h0, 32'hFFFF_FFFF, 16'h0001, 32'd10, 32'h1}, 1, STS_IGNORED, 11'd0},
    '{'{OP_START, 32'h0A00_0001, 32'hFFFF_FFFF, 16'h0, 32'h0, 32'h0}, 1, STS_UPDATED, 11'd1},
    '{'{OP_STOP, 32'h0A00_0001, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFF, 32'h0}, 1, STS_UPDATED, 11'd1},
    '{'{OP_START, 32'h0A00_0001, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFF, 32'h5}, 1, STS_UPDATED, 11'd1},
    '{'{OP_START, 32'h0A00_0001, 32'hFFFF_FFFF, 16'h0, 32'h0, 32'h5}, 1, STS_UPDATED, 11'd1},
    '{'{OP_STOP, 32'h0A00_0001, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFF, 32'h0}, 1, STS_UPDATED, 11'd1},
    '{'{OP_ALIVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      1, STS_UPDATED, 11'd2},
    '{'{OP_OTHER, 32'h0A00_0002, 32'hFFFF_FF00, 16'h0, 32'h7, 32'h0}, 1, STS_UPDATED, 11'd1},
    '{'{OP_OTHER, 32'h0B00_0000, 32'h0, 16'h0, 32'h7, 32'h0}, 1, STS_UPDATED, 11'd1},
    '{'{OP_STOP, 32'h0A00_0001, 32'hFFFF_FFFF, 16'h0, 32'h5, 32'h0}, 1, STS_UPDATED, 11'd1},
    '{'{OP_START, 32'h5555_5555, 32'hFFFF_FFFF, 16'hAAAA, 32'd1234, 32'hAAAA_AAAA},
      1, STS_UPDATED, 11'd3},
    '{'{OP_STOP, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 16'h5555, 32'h0, 32'h5555_5555},
      1, STS_UPDATED, 11'd4},
    '{'{OP_START, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 16'h5555, 32'h0, 32'h1}, 0, STS_UPDATED, 11'd0},
    '{'{OP_STOP, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 16'h5555, 32'd100, 32'h2}, 0, STS_UPDATED, 11'd0}
  };

  // main sequence: reset, directed rows, then random phases over several limits
  initial begin
    int unsigned drain;
    foreach (srv_pool[i]) srv_pool[i] = $urandom | 32'h1;
    foreach (port_pool[i]) port_pool[i] = 16'($urandom);
    port_pool[0] = 16'h0;
    port_pool[1] = 16'hFFFF;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      offer_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].status, dir_rows[i].idx);
      idle_gap($urandom_range(0, 2));
    end
    write_limit(11'd2047);
    random_phase(150);
    write_limit(11'd3);
    random_phase(60);
    write_limit(11'd0);
    random_phase(25);
    write_limit(11'd1);
    random_phase(25);
    write_limit(11'd1024);
    hold_go = 1'b1;
    random_phase(265);
    in_valid_i <= 1'b0;
    drain = 0;
    while (pending_stats.size() != 0 && drain < 200000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (1100) @(posedge clk_i);
    $display("covered %0d results (%0d table full, %0d ignored, %0d negative intervals)",
             n_results, n_full, n_ignored, n_neg);
    $display("limits 1024, 2047, 3, 0, 1; %0d ports in use at the end", used_cnt);
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/pss_pkg.sv
rtl/core/pss_ctrl.sv
rtl/core/pss_datapath.sv
rtl/core/port_session_stats_table_unit.sv
rtl/core/pss_checker.sv
bench/testbench.sv
